// ===== hdl/lcgbrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgbrg_pkg
// Shared types and constants of the LCG bounded random generator.
// ----------------------------------------------------------------------------
package lcgbrg_pkg;

  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned STATE_W  = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned VALUE_W  = 17;
  localparam int unsigned ADDR_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DRAW_W);

  localparam logic [STATE_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [STATE_W-1:0] LCG_INC = 32'd12345;
  localparam logic [DRAW_W-1:0]  FOLD_MAX = 16'h7fff;

  localparam logic [KIND_W-1:0] KIND_RAW     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FOLD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOUNDED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MIN2    = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_SEED = 2'd0;

  typedef struct packed {
    logic              latch_item;
    logic              step;
    logic              div_start;
    logic              div_sel_mod;
    logic              latch_bound;
    logic              latch_first;
    logic              load_out;
    logic [KIND_W-1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic reject;
  } status_t;

endpackage

// ===== hdl/lcg_bounded_random_generator.sv =====
// ----------------------------------------------------------------------------
// lcg_bounded_random_generator
// LCG random source with raw, folded, bounded and min-of-two bounded draws.
// ----------------------------------------------------------------------------
// One item at a time. Raw and folded kinds step the LCG, take the draw and then
// load the output register. Bounded kinds first run a remainder on the divider
// to find the rejection bound. Each draw then steps the LCG and is checked
// against the bound. The final reduction runs on the same shared bit-serial
// divider, and then the output register is loaded. Min-of-two runs the draw
// and reduction twice; a rejected draw is stepped again. The next item is taken
// in the cycle after the output load. The result sits in an output register,
// so the next item is taken while a result still waits. That item then holds
// in its final state until the waiting result leaves. Writing the seed
// register reloads the LCG state.
// ----------------------------------------------------------------------------
module lcg_bounded_random_generator #(
  parameter int unsigned RANGE_LIMIT = 65535
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lcgbrg_pkg::ADDR_W-1:0]          paddr,
  input  logic [lcgbrg_pkg::DATA_W-1:0]          pwdata,
  output logic [lcgbrg_pkg::DATA_W-1:0]          prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [lcgbrg_pkg::KIND_W-1:0]          in_kind,
  input  logic [lcgbrg_pkg::LIMIT_W-1:0]         in_limit,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lcgbrg_pkg::VALUE_W-1:0]  out_value
);

  lcgbrg_pkg::cmd_t                cmd;
  lcgbrg_pkg::status_t             status;
  logic                            seed_we;
  logic [lcgbrg_pkg::DATA_W-1:0]   seed_rdata;

  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr == lcgbrg_pkg::ADDR_SEED);
  assign prdata  = (paddr == lcgbrg_pkg::ADDR_SEED) ? seed_rdata : '0;

  lcgbrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lcgbrg_dp #(
    .RANGE_LIMIT (RANGE_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed_we    (seed_we),
    .seed_wdata (pwdata),
    .seed_rdata (seed_rdata),
    .in_limit   (in_limit),
    .cmd        (cmd),
    .status     (status),
    .out_value  (out_value)
  );

endmodule

// ===== hdl/lcgbrg_div.sv =====
// ----------------------------------------------------------------------------
// lcgbrg_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module lcgbrg_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lcgbrg_pkg::DRAW_W-1:0]   dividend,
  input  logic [lcgbrg_pkg::DRAW_W-1:0]   divisor,
  output logic                            done,
  output logic [lcgbrg_pkg::DRAW_W-1:0]   remainder
);

  logic [lcgbrg_pkg::DRAW_W-1:0]    rem_r;
  logic [lcgbrg_pkg::DRAW_W-1:0]    dvd_r;
  logic [lcgbrg_pkg::DRAW_W-1:0]    dvs_r;
  logic [lcgbrg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [lcgbrg_pkg::DRAW_W:0]      trial;
  logic [lcgbrg_pkg::DRAW_W:0]      diff;
  logic                             ge;

  assign trial = {rem_r, dvd_r[lcgbrg_pkg::DRAW_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {lcgbrg_pkg::DIV_CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[lcgbrg_pkg::DRAW_W-1:0] : trial[lcgbrg_pkg::DRAW_W-1:0];
      dvd_r <= {dvd_r[lcgbrg_pkg::DRAW_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/lcgbrg_dp.sv =====
// ----------------------------------------------------------------------------
// lcgbrg_dp
// Datapath: seed and LCG state, rejection bound, divider, result register.
// ----------------------------------------------------------------------------
module lcgbrg_dp #(
  parameter int unsigned RANGE_LIMIT = 65535
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             seed_we,
  input  logic [lcgbrg_pkg::DATA_W-1:0]    seed_wdata,
  output logic [lcgbrg_pkg::DATA_W-1:0]    seed_rdata,
  input  logic [lcgbrg_pkg::LIMIT_W-1:0]   in_limit,
  input  lcgbrg_pkg::cmd_t                 cmd,
  output lcgbrg_pkg::status_t              status,
  output logic signed [lcgbrg_pkg::VALUE_W-1:0] out_value
);

  localparam logic [lcgbrg_pkg::DRAW_W-1:0] RANGE_LIM_C = RANGE_LIMIT[lcgbrg_pkg::DRAW_W-1:0];

  logic [lcgbrg_pkg::STATE_W-1:0] seed_r;
  logic [lcgbrg_pkg::STATE_W-1:0] state_r;
  logic [lcgbrg_pkg::DRAW_W-1:0]  span_r;
  logic [lcgbrg_pkg::DRAW_W-1:0]  bound_r;
  logic [lcgbrg_pkg::DRAW_W-1:0]  first_r;
  logic [lcgbrg_pkg::VALUE_W-1:0] value_r;
  logic [lcgbrg_pkg::STATE_W-1:0] state_step;
  logic [lcgbrg_pkg::DRAW_W-1:0]  draw;
  logic [lcgbrg_pkg::DRAW_W-1:0]  span_in;
  logic [lcgbrg_pkg::DRAW_W-1:0]  div_dividend;
  logic [lcgbrg_pkg::DRAW_W-1:0]  div_divisor;
  logic [lcgbrg_pkg::DRAW_W-1:0]  rem;
  logic                           div_done;
  logic [lcgbrg_pkg::DRAW_W-1:0]  min_val;
  logic [lcgbrg_pkg::VALUE_W-1:0] result;

  assign state_step   = state_r * lcgbrg_pkg::LCG_MUL + lcgbrg_pkg::LCG_INC;
  assign draw         = state_r[lcgbrg_pkg::DRAW_W+7:8];
  assign span_in      = {1'b0, in_limit} + 1'b1;
  assign div_dividend = cmd.div_sel_mod ? draw : RANGE_LIM_C;
  assign div_divisor  = cmd.latch_item ? span_in : span_r;

  lcgbrg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      state_r <= '0;
    end else if (seed_we) begin
      seed_r  <= seed_wdata;
      state_r <= seed_wdata;
    end else if (cmd.step) begin
      state_r <= state_step;
    end
  end

  // bound = RANGE_LIMIT - RANGE_LIMIT % span; zero when span exceeds the range
  always_ff @(posedge clk) begin
    if (cmd.latch_item)  span_r  <= span_in;
    if (cmd.latch_bound) bound_r <= RANGE_LIM_C - rem;
    if (cmd.latch_first) first_r <= rem;
    if (cmd.load_out)    value_r <= result;
  end

  assign min_val = (first_r < rem) ? first_r : rem;

  always_comb begin
    case (cmd.kind)
      lcgbrg_pkg::KIND_RAW:     result = {1'b0, draw};
      lcgbrg_pkg::KIND_FOLD:    result = (draw > lcgbrg_pkg::FOLD_MAX)
                                         ? ({1'b0, lcgbrg_pkg::FOLD_MAX} - {1'b0, draw})
                                         : {1'b0, draw};
      lcgbrg_pkg::KIND_BOUNDED: result = {1'b0, rem};
      lcgbrg_pkg::KIND_MIN2:    result = {1'b0, min_val};
      default:                  result = {1'b0, draw};
    endcase
  end

  assign status.div_done = div_done;
  assign status.reject   = (bound_r != '0) && (draw >= bound_r);
  assign seed_rdata      = seed_r;
  assign out_value       = value_r;

endmodule

// ===== hdl/lcgbrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcgbrg_ctrl
// Sequencer: bound computation, draw and rejection loop, output handshake.
// ----------------------------------------------------------------------------
module lcgbrg_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lcgbrg_pkg::KIND_W-1:0]     in_kind,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  lcgbrg_pkg::status_t               status,
  output lcgbrg_pkg::cmd_t                  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BDIV  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MDIV  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [lcgbrg_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic                            second_r, second_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            accept;
  logic                            bounded_kind;

  assign accept       = in_valid && (state_r == S_IDLE);
  assign bounded_kind = (kind_r == lcgbrg_pkg::KIND_BOUNDED) ||
                        (kind_r == lcgbrg_pkg::KIND_MIN2);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.kind      = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          second_nxt     = 1'b0;
          cmd.latch_item = 1'b1;
          if ((in_kind == lcgbrg_pkg::KIND_BOUNDED) ||
              (in_kind == lcgbrg_pkg::KIND_MIN2)) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_BDIV;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_BDIV: begin
        if (status.div_done) begin
          cmd.latch_bound = 1'b1;
          state_nxt       = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!bounded_kind) begin
          state_nxt = S_DONE;
        end else if (status.reject) begin
          state_nxt = S_STEP;
        end else begin
          cmd.div_start   = 1'b1;
          cmd.div_sel_mod = 1'b1;
          state_nxt       = S_MDIV;
        end
      end
      S_MDIV: begin
        if (status.div_done) begin
          if ((kind_r == lcgbrg_pkg::KIND_MIN2) && !second_r) begin
            cmd.latch_first = 1'b1;
            second_nxt      = 1'b1;
            state_nxt       = S_STEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= lcgbrg_pkg::KIND_RAW;
      second_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      second_r    <= second_nxt;
    end
  end

  assign in_stall  = !(state_r == S_IDLE) || (accept && 1'b0);
  assign out_valid = out_valid_r;

endmodule
